[sv/srd_pkg.sv]
// Shared types and constants for the signed rounding divider.
package srd_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned Latency   = DataWidth + 3;

  localparam logic [DataWidth:0] NegLimit = (DataWidth + 1)'(1) << (DataWidth - 1);
  localparam logic [DataWidth:0] PosLimit = NegLimit - (DataWidth + 1)'(1);

  typedef struct packed {
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] quo;
    logic [DataWidth-1:0] ay;
    logic                 neg;
    logic                 dbz;
  } div_stage_t;

  typedef struct packed {
    logic [DataWidth:0] q;
    logic               neg;
    logic               dbz;
  } round_t;

endpackage

[sv/signed_rounding_divider_top.sv]
// Top level of the pipelined signed rounding divider.
//
// Channel  | Direction | Handshake                 | Payload
// request  | in        | start_i, busy_o           | dividend_i, divisor_i
// result   | out       | result_valid_o (strobe)   | quotient_o, divide_by_zero_o,
//          |           |                           | overflowed_o
//
// A request is taken in every cycle; busy_o stays low.
// A request passes through one operand stage, one restoring step per
// quotient bit, one rounding stage and one saturation stage.
// Reset clears the valid bits of every stage; payload registers are not reset.
// The receiver cannot stall, so each result shows for exactly one cycle.
module signed_rounding_divider_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [srd_pkg::DataWidth-1:0] dividend_i,
  input  logic [srd_pkg::DataWidth-1:0] divisor_i,
  output logic                          result_valid_o,
  output logic [srd_pkg::DataWidth-1:0] quotient_o,
  output logic                          divide_by_zero_o,
  output logic                          overflowed_o
);
  import srd_pkg::*;

  logic       valid_w [DataWidth+1];
  div_stage_t stage_w [DataWidth+1];

  assign busy_o = 1'b0;

  srd_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (start_i && !busy_o),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .valid_o    (valid_w[0]),
    .stage_o    (stage_w[0])
  );

  for (genvar i = 0; i < DataWidth; i++) begin : g_step
    srd_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[i]),
      .stage_i (stage_w[i]),
      .valid_o (valid_w[i+1]),
      .stage_o (stage_w[i+1])
    );
  end

  srd_post u_post (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_w[DataWidth]),
    .stage_i          (stage_w[DataWidth]),
    .valid_o          (result_valid_o),
    .quotient_o       (quotient_o),
    .divide_by_zero_o (divide_by_zero_o),
    .overflowed_o     (overflowed_o)
  );

endmodule

[sv/srd_prep.sv]
// Operand magnitude and sign capture, first pipeline stage.
module srd_prep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [srd_pkg::DataWidth-1:0] dividend_i,
  input  logic [srd_pkg::DataWidth-1:0] divisor_i,
  output logic                         valid_o,
  output srd_pkg::div_stage_t          stage_o
);
  import srd_pkg::*;

  logic                 valid_q;
  div_stage_t           stage_d, stage_q;
  logic                 nx, ny;
  logic [DataWidth-1:0] ax, ay;

  always_comb begin
    nx = dividend_i[DataWidth-1];
    ny = divisor_i[DataWidth-1];
    ax = nx ? (~dividend_i + DataWidth'(1)) : dividend_i;
    ay = ny ? (~divisor_i + DataWidth'(1)) : divisor_i;
    stage_d.rem = '0;
    stage_d.quo = ax;
    stage_d.ay  = ay;
    stage_d.neg = nx ^ ny;
    stage_d.dbz = (ay == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[sv/srd_div_step.sv]
// One restoring division step, registered.
module srd_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  srd_pkg::div_stage_t stage_i,
  output logic                valid_o,
  output srd_pkg::div_stage_t stage_o
);
  import srd_pkg::*;

  logic               valid_q;
  div_stage_t         stage_d, stage_q;
  logic [DataWidth:0] shifted;
  logic [DataWidth:0] diff;
  logic               ge;

  always_comb begin
    shifted = {stage_i.rem, stage_i.quo[DataWidth-1]};
    diff    = shifted - {1'b0, stage_i.ay};
    ge      = (shifted >= {1'b0, stage_i.ay});
    stage_d     = stage_i;
    stage_d.rem = ge ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
    stage_d.quo = {stage_i.quo[DataWidth-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[sv/srd_post.sv]
// Rounding, sign restore and saturation, last two pipeline stages.
module srd_post (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  srd_pkg::div_stage_t           stage_i,
  output logic                          valid_o,
  output logic [srd_pkg::DataWidth-1:0] quotient_o,
  output logic                          divide_by_zero_o,
  output logic                          overflowed_o
);
  import srd_pkg::*;

  logic                 rnd_valid_q, out_valid_q;
  round_t               rnd_d, rnd_q;
  logic [DataWidth-1:0] half_gap;
  logic                 negq;
  logic [DataWidth:0]   mag;
  logic                 ovf;
  logic [DataWidth:0]   signed_res;
  logic [DataWidth-1:0] quo_d, quo_q;
  logic                 dbz_d, dbz_q, ovf_d, ovf_q;

  always_comb begin
    half_gap  = stage_i.ay - stage_i.rem;
    rnd_d.q   = {1'b0, stage_i.quo} + (DataWidth + 1)'(stage_i.rem >= half_gap);
    rnd_d.neg = stage_i.neg;
    rnd_d.dbz = stage_i.dbz;
  end

  always_comb begin
    negq = rnd_q.neg && (rnd_q.q != '0);
    mag  = rnd_q.q;
    ovf  = 1'b0;
    if (negq) begin
      if (rnd_q.q > NegLimit) begin
        mag = NegLimit;
        ovf = 1'b1;
      end
      signed_res = ~mag + (DataWidth + 1)'(1);
    end else begin
      if (rnd_q.q > PosLimit) begin
        mag = PosLimit;
        ovf = 1'b1;
      end
      signed_res = mag;
    end
    if (rnd_q.dbz) begin
      quo_d = '0;
      ovf_d = 1'b0;
    end else begin
      quo_d = signed_res[DataWidth-1:0];
      ovf_d = ovf;
    end
    dbz_d = rnd_q.dbz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rnd_valid_q <= valid_i;
      out_valid_q <= rnd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rnd_q <= rnd_d;
    end
    if (rnd_valid_q) begin
      quo_q <= quo_d;
      dbz_q <= dbz_d;
      ovf_q <= ovf_d;
    end
  end

  assign valid_o          = out_valid_q;
  assign quotient_o       = quo_q;
  assign divide_by_zero_o = dbz_q;
  assign overflowed_o     = ovf_q;

endmodule

[sv/srd_checker.sv]
// Port-level checker for the signed rounding divider, with its bind.
module srd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [srd_pkg::DataWidth-1:0] divisor_i,
  input logic                          result_valid_o,
  input logic [srd_pkg::DataWidth-1:0] quotient_o,
  input logic                          divide_by_zero_o,
  input logic                          overflowed_o
);
  import srd_pkg::*;

  localparam int unsigned CntW = $clog2(Latency + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Latency);

  logic [CntW-1:0] cnt_d, cnt_q;
  logic            warm;

  assign cnt_d = (cnt_q == CntMax) ? cnt_q : cnt_q + CntW'(1);
  assign warm  = (cnt_q == CntMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");

  a_one_result_per_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (result_valid_o == $past(start_i && !busy_o, Latency)))
    else $error("result strobe does not match request");

  a_dbz_follows_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && result_valid_o) |-> (divide_by_zero_o == $past(divisor_i == '0, Latency)))
    else $error("divide by zero flag mismatch");

  a_dbz_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && divide_by_zero_o) |-> (quotient_o == '0 && !overflowed_o))
    else $error("divide by zero result not clean");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && overflowed_o) |->
      (quotient_o == PosLimit[DataWidth-1:0] || quotient_o == NegLimit[DataWidth-1:0]))
    else $error("overflow without saturated quotient");

endmodule

bind signed_rounding_divider_top srd_checker u_srd_checker (.*);

[tb/sv/signed_rounding_divider_top_tb.sv]
// Self-checking testbench for the signed rounding divider: directed table, then random traffic.
`timescale 1ns / 1ps

module signed_rounding_divider_top_tb;

  localparam int unsigned W          = srd_pkg::DataWidth;
  localparam int          StallLimit = 4000;
  localparam int          RandomPerPhase = 334;

  localparam logic [W:0]   MagLimit = (W + 1)'(1) << (W - 1);
  localparam logic [W-1:0] MinInt   = {1'b1, {(W - 1){1'b0}}};
  localparam logic [W-1:0] MaxInt   = {1'b0, {(W - 1){1'b1}}};

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         dbz;
    logic         ovf;
  } div_result_t;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic         typed;
    div_result_t  want;
  } div_case_t;

  localparam div_result_t Untyped = '{W'(0), 1'b0, 1'b0};

  localparam div_case_t DirectedCases [24] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{32'h7fff_ffff, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{32'h8000_0000, 32'hffff_ffff, 1'b1, '{32'h7fff_ffff, 1'b0, 1'b1}},
    '{32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
    '{32'h7fff_ffff, 32'h0000_0001, 1'b1, '{32'h7fff_ffff, 1'b0, 1'b0}},
    '{32'h7fff_ffff, 32'hffff_ffff, 1'b1, '{32'h8000_0001, 1'b0, 1'b0}},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0001, 1'b0, 1'b0}},
    '{32'h7fff_ffff, 32'h7fff_ffff, 1'b1, '{32'h0000_0001, 1'b0, 1'b0}},
    '{32'h0000_0000, 32'h0000_0005, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{32'h0000_0000, 32'hffff_fffb, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{32'h0000_0007, 32'h0000_0002, 1'b0, Untyped},
    '{32'hffff_fff9, 32'h0000_0002, 1'b0, Untyped},
    '{32'h0000_0005, 32'h0000_0002, 1'b0, Untyped},
    '{32'hffff_fffb, 32'h0000_0002, 1'b0, Untyped},
    '{32'h0000_0001, 32'h0000_0003, 1'b0, Untyped},
    '{32'h0000_0002, 32'h0000_0003, 1'b0, Untyped},
    '{32'hffff_ffff, 32'h0000_0002, 1'b0, Untyped},
    '{32'h0000_0001, 32'hffff_fffe, 1'b0, Untyped},
    '{32'h7fff_ffff, 32'h0000_0002, 1'b0, Untyped},
    '{32'h8000_0000, 32'hffff_fffe, 1'b0, Untyped},
    '{32'h8000_0000, 32'h7fff_ffff, 1'b0, Untyped},
    '{32'h7fff_ffff, 32'h8000_0000, 1'b0, Untyped},
    '{32'h0000_0001, 32'h8000_0000, 1'b0, Untyped}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         start_i;
  logic         busy_o;
  logic [W-1:0] dividend_i;
  logic [W-1:0] divisor_i;
  logic         result_valid_o;
  logic [W-1:0] quotient_o;
  logic         divide_by_zero_o;
  logic         overflowed_o;

  div_result_t  expected_quotients [$];
  int           mismatches   = 0;
  int           quiet_cycles = 0;

  signed_rounding_divider_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .dividend_i       (dividend_i),
    .divisor_i        (divisor_i),
    .result_valid_o   (result_valid_o),
    .quotient_o       (quotient_o),
    .divide_by_zero_o (divide_by_zero_o),
    .overflowed_o     (overflowed_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic div_result_t round_divide(logic [W-1:0] num, logic [W-1:0] den);
    logic [W:0]  mag_num;
    logic [W:0]  mag_den;
    logic [W:0]  quo;
    logic [W:0]  rem;
    logic        negative;
    div_result_t res;
    res = '{W'(0), 1'b0, 1'b0};
    mag_num = {1'b0, num[W-1] ? W'(-num) : num};
    mag_den = {1'b0, den[W-1] ? W'(-den) : den};
    if (mag_den == '0) begin
      res.dbz = 1'b1;
      return res;
    end
    quo = mag_num / mag_den;
    rem = mag_num % mag_den;
    if (rem >= mag_den - rem) quo = quo + 1'b1;
    negative = (num[W-1] != den[W-1]) && (quo != '0);
    if (negative) begin
      if (quo > MagLimit) begin
        quo     = MagLimit;
        res.ovf = 1'b1;
      end
      res.quotient = W'(-quo);
    end else begin
      if (quo > MagLimit - 1'b1) begin
        quo     = MagLimit - 1'b1;
        res.ovf = 1'b1;
      end
      res.quotient = W'(quo);
    end
    return res;
  endfunction

  function automatic logic [W-1:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        return MinInt + W'($urandom_range(0, 3));
      end
      1: begin
        return MaxInt - W'($urandom_range(0, 3));
      end
      2, 3: begin
        return W'($urandom_range(0, 40)) - W'(20);
      end
      4: begin
        return W'($urandom_range(0, 2)) - W'(1);
      end
      5: begin
        return W'($urandom_range(0, 65535)) << $urandom_range(0, 16);
      end
      default: begin
        return W'($urandom());
      end
    endcase
  endfunction

  task automatic make_operands(output logic [W-1:0] num, output logic [W-1:0] den);
    int          sel;
    logic [W-1:0] half_den;
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      num = MinInt;
      den = {W{1'b1}};
    end else if (sel < 18) begin
      // build an exact tie: num = k * den + den / 2
      den      = W'($urandom_range(1, 32767)) << 1;
      half_den = den >> 1;
      num      = W'($urandom_range(0, 32767)) * den + half_den;
      if ($urandom_range(0, 1)) num = -num;
      if ($urandom_range(0, 1)) den = -den;
    end else begin
      num = pick_operand();
      den = pick_operand();
    end
  endtask

  task automatic send_request(input logic [W-1:0] num, input logic [W-1:0] den,
                              input logic typed, input div_result_t want,
                              input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i    = 1'b1;
    dividend_i = num;
    divisor_i  = den;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_quotients.push_back(typed ? want : round_divide(num, den));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i = 1'b0;
    while (expected_quotients.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    div_result_t got;
    div_result_t want;
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end else if (result_valid_o) begin
        got = '{quotient_o, divide_by_zero_o, overflowed_o};
        if (expected_quotients.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: quotient=%0d dbz=%0b ovf=%0b",
                     $signed(got.quotient), got.dbz, got.ovf);
        end else begin
          want = expected_quotients.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: quotient exp %0d got %0d, ",
                        "dbz exp %0b got %0b, ovf exp %0b got %0b"},
                       $signed(want.quotient), $signed(got.quotient),
                       want.dbz, got.dbz, want.ovf, got.ovf);
          end
        end
      end
    end
  end

  initial begin
    logic [W-1:0] num;
    logic [W-1:0] den;
    int           idle_pct;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    dividend_i = '0;
    divisor_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirectedCases[i])
      send_request(DirectedCases[i].num, DirectedCases[i].den, DirectedCases[i].typed,
                   DirectedCases[i].want, 19);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 19 : (phase == 1) ? 85 : 0;
      for (int n = 0; n < RandomPerPhase; n++) begin
        make_operands(num, den);
        send_request(num, den, 1'b0, Untyped, idle_pct);
      end
      // hold off new requests until the pipeline is empty
      if (phase == 0) drain_results();
    end

    drain_results();
    repeat (srd_pkg::Latency + 5) @(negedge clk_i);
    if (mismatches == 0 && expected_quotients.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
